// ===== hw/rtl/mer_pkg.sv =====
// shared types and constants of the midpoint ellipse rasterizer
package mer_pkg;

   localparam int COLOR_W = 4;

   // request command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT_RX,
      ST_INIT_RY,
      ST_INIT_PROD,
      ST_INIT_SLOPE,
      ST_SW_U,
      ST_SW_USQ,
      ST_SW_V,
      ST_SW_VSQ,
      ST_SW_W,
      ST_SW_WSQ,
      ST_SW_DONE,
      ST_STEP,
      ST_DELTA,
      ST_DECIDE,
      ST_EMIT_PT,
      ST_EMIT_BLANK
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_INIT_RX2,
      DP_INIT_RY2,
      DP_INIT_SLOPE,
      DP_SW_SET,
      DP_SW_ADD,
      DP_SW_SUB,
      DP_STEP_ONE,
      DP_STEP_TWO,
      DP_DELTA,
      DP_DEC_UPD
   } dp_op_type;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_RX_RX,
      MUL_RY_RY,
      MUL_RX2_RY,
      MUL_RY_TX,
      MUL_PROD_SQ,
      MUL_RX_TY,
      MUL_RX_RY
   } mul_sel_type;

   typedef struct packed {
      dp_op_type   dp_op;
      mul_sel_type mul_sel;
      logic        out_load;
      logic        out_blank;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic region_two;
      logic r1_cond;
   } status_type;

endpackage

// ===== hw/rtl/mer_if.sv =====
// request and response channel interfaces of the ellipse rasterizer
interface mer_req_if #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [COORD_BITS-1:0]        center_x;
   logic [COORD_BITS-1:0]        center_y;
   logic [RADIUS_BITS-1:0]       radius_x;
   logic [RADIUS_BITS-1:0]       radius_y;
   logic [mer_pkg::COLOR_W-1:0]  pen_color;

   modport source (
      output valid, command, center_x, center_y, radius_x, radius_y, pen_color,
      input  ready
   );
   modport sink (
      input  valid, command, center_x, center_y, radius_x, radius_y, pen_color,
      output ready
   );
endinterface

interface mer_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_BITS+1:0]   right_x;
   logic signed [COORD_BITS+1:0]   left_x;
   logic signed [COORD_BITS+1:0]   lower_y;
   logic signed [COORD_BITS+1:0]   upper_y;
   logic [mer_pkg::COLOR_W-1:0]    point_color;
   logic                           plot_valid;
   logic                           done_res;

   modport source (
      output valid, right_x, left_x, lower_y, upper_y, point_color, plot_valid,
             done_res,
      input  ready
   );
   modport sink (
      input  valid, right_x, left_x, lower_y, upper_y, point_color, plot_valid,
             done_res,
      output ready
   );
endinterface

// ===== hw/rtl/mer_dp.sv =====
// datapath of the ellipse rasterizer: shared multiplier, stepping state, result register
module mer_dp #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mer_pkg::cmd_type              cmd,
   output mer_pkg::status_type           status,
   input  logic [COORD_BITS-1:0]         req_center_x,
   input  logic [COORD_BITS-1:0]         req_center_y,
   input  logic [RADIUS_BITS-1:0]        req_radius_x,
   input  logic [RADIUS_BITS-1:0]        req_radius_y,
   input  logic [mer_pkg::COLOR_W-1:0]   req_pen_color,
   output logic signed [COORD_BITS+1:0]  rsp_right_x,
   output logic signed [COORD_BITS+1:0]  rsp_left_x,
   output logic signed [COORD_BITS+1:0]  rsp_lower_y,
   output logic signed [COORD_BITS+1:0]  rsp_upper_y,
   output logic [mer_pkg::COLOR_W-1:0]   rsp_point_color,
   output logic                          rsp_plot_valid,
   output logic                          rsp_done_res
);

   localparam int RB      = RADIUS_BITS;
   localparam int SQ_W    = 2 * RB;
   localparam int X_W     = RB + 1;
   localparam int MUL_W   = 2 * RB + 2;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SLOPE_W = 3 * RB + 7;
   localparam int DELTA_W = SLOPE_W + 2;
   localparam int DEC_W   = (4 * RB + 4 > SLOPE_W + 4) ? 4 * RB + 4 : SLOPE_W + 4;
   localparam int OUT_W   = COORD_BITS + 2;
   localparam int EXT_W   = (OUT_W > X_W + 1) ? OUT_W : X_W + 1;

   logic [RB-1:0]                  rx_ff, rx_in, ry_ff, ry_in;
   logic [COORD_BITS-1:0]          cx_ff, cx_in, cy_ff, cy_in;
   logic [mer_pkg::COLOR_W-1:0]    color_ff, color_in;
   logic [SQ_W-1:0]                rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [X_W-1:0]                 step_x_ff, step_x_in;
   logic [RB-1:0]                  step_y_ff, step_y_in;
   logic [SLOPE_W-1:0]             slope_x_ff, slope_x_in, slope_y_ff, slope_y_in;
   logic signed [DEC_W-1:0]        decision_ff, decision_in;
   logic [PROD_W-1:0]              prod_ff;
   logic signed [DELTA_W-1:0]      delta_ff, delta_in;
   logic                           x_stepped_ff, x_stepped_in;
   logic                           y_stepped_ff, y_stepped_in;
   logic                           region_two_ff, region_two_in;
   logic                           active_ff, active_in;

   logic [MUL_W-1:0]               mul_a, mul_b;
   logic [PROD_W-1:0]              mul_out;
   logic signed [DEC_W-1:0]        prod_ext;
   logic [SLOPE_W-1:0]             two_rx2, two_ry2;
   logic [SQ_W-1:0]                delta_base;
   logic                           dec_neg;

   logic signed [OUT_W-1:0]        right_x_ff, left_x_ff, lower_y_ff, upper_y_ff;
   logic [mer_pkg::COLOR_W-1:0]    out_color_ff;
   logic                           plot_valid_ff, done_ff;

   // operand selection for the one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         mer_pkg::MUL_RX_RX: begin
            mul_a = MUL_W'(rx_ff);
            mul_b = MUL_W'(rx_ff);
         end
         mer_pkg::MUL_RY_RY: begin
            mul_a = MUL_W'(ry_ff);
            mul_b = MUL_W'(ry_ff);
         end
         mer_pkg::MUL_RX2_RY: begin
            mul_a = MUL_W'(rx2_ff);
            mul_b = MUL_W'(ry_ff);
         end
         mer_pkg::MUL_RY_TX: begin
            mul_a = MUL_W'(ry_ff);
            mul_b = MUL_W'({step_x_ff, 1'b1});
         end
         mer_pkg::MUL_PROD_SQ: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = prod_ff[MUL_W-1:0];
         end
         mer_pkg::MUL_RX_TY: begin
            mul_a = MUL_W'(rx_ff);
            mul_b = MUL_W'(step_y_ff - RB'(1));
         end
         mer_pkg::MUL_RX_RY: begin
            mul_a = MUL_W'(rx_ff);
            mul_b = MUL_W'(ry_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_ext = DEC_W'(prod_ff);
   assign two_rx2  = SLOPE_W'({rx2_ff, 1'b0});
   assign two_ry2  = SLOPE_W'({ry2_ff, 1'b0});
   assign dec_neg  = decision_ff[DEC_W-1];
   assign delta_base = region_two_ff ? rx2_ff : ry2_ff;

   always_comb begin
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      color_in      = color_ff;
      rx2_in        = rx2_ff;
      ry2_in        = ry2_ff;
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      slope_x_in    = slope_x_ff;
      slope_y_in    = slope_y_ff;
      decision_in   = decision_ff;
      delta_in      = delta_ff;
      x_stepped_in  = x_stepped_ff;
      y_stepped_in  = y_stepped_ff;
      region_two_in = region_two_ff;
      active_in     = active_ff;
      case (cmd.dp_op)
         mer_pkg::DP_LOAD: begin
            rx_in         = req_radius_x;
            ry_in         = req_radius_y;
            cx_in         = req_center_x;
            cy_in         = req_center_y;
            color_in      = req_pen_color;
            step_x_in     = '0;
            step_y_in     = req_radius_y;
            slope_x_in    = '0;
            region_two_in = 1'b0;
         end
         mer_pkg::DP_INIT_RX2: begin
            rx2_in      = prod_ff[SQ_W-1:0];
            decision_in = prod_ext;
         end
         mer_pkg::DP_INIT_RY2: begin
            ry2_in      = prod_ff[SQ_W-1:0];
            decision_in = decision_ff + (prod_ext <<< 2);
         end
         mer_pkg::DP_INIT_SLOPE: begin
            slope_y_in  = SLOPE_W'(prod_ff) << 1;
            decision_in = decision_ff - (prod_ext <<< 2);
            active_in   = (ry_ff != '0);
         end
         mer_pkg::DP_SW_SET: begin
            decision_in = prod_ext;
         end
         mer_pkg::DP_SW_ADD: begin
            decision_in = decision_ff + (prod_ext <<< 2);
         end
         mer_pkg::DP_SW_SUB: begin
            decision_in   = decision_ff - (prod_ext <<< 2);
            region_two_in = 1'b1;
         end
         mer_pkg::DP_STEP_ONE: begin
            step_x_in    = step_x_ff + X_W'(1);
            slope_x_in   = slope_x_ff + two_ry2;
            x_stepped_in = 1'b1;
            y_stepped_in = !dec_neg;
            if (!dec_neg) begin
               step_y_in  = step_y_ff - RB'(1);
               slope_y_in = slope_y_ff - two_rx2;
            end
         end
         mer_pkg::DP_STEP_TWO: begin
            step_y_in    = step_y_ff - RB'(1);
            slope_y_in   = slope_y_ff - two_rx2;
            y_stepped_in = 1'b1;
            x_stepped_in = dec_neg;
            if (dec_neg) begin
               step_x_in  = step_x_ff + X_W'(1);
               slope_x_in = slope_x_ff + two_ry2;
            end
         end
         mer_pkg::DP_DELTA: begin
            delta_in = DELTA_W'(delta_base)
                     + (x_stepped_ff ? DELTA_W'(slope_x_ff) : DELTA_W'(0))
                     - (y_stepped_ff ? DELTA_W'(slope_y_ff) : DELTA_W'(0));
         end
         mer_pkg::DP_DEC_UPD: begin
            decision_in = decision_ff + (DEC_W'(delta_ff) <<< 2);
            if (step_y_ff == '0) begin
               active_in = 1'b0;
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      color_ff     <= color_in;
      rx2_ff       <= rx2_in;
      ry2_ff       <= ry2_in;
      step_x_ff    <= step_x_in;
      step_y_ff    <= step_y_in;
      slope_x_ff   <= slope_x_in;
      slope_y_ff   <= slope_y_in;
      decision_ff  <= decision_in;
      prod_ff      <= mul_out;
      delta_ff     <= delta_in;
      x_stepped_ff <= x_stepped_in;
      y_stepped_ff <= y_stepped_in;
      if (reset) begin
         region_two_ff <= 1'b0;
         active_ff     <= 1'b0;
      end else begin
         region_two_ff <= region_two_in;
         active_ff     <= active_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_blank) begin
            right_x_ff    <= '0;
            left_x_ff     <= '0;
            lower_y_ff    <= '0;
            upper_y_ff    <= '0;
            out_color_ff  <= '0;
            plot_valid_ff <= 1'b0;
            done_ff       <= 1'b1;
         end else begin
            right_x_ff    <= OUT_W'(EXT_W'(cx_ff) + EXT_W'(step_x_ff));
            left_x_ff     <= OUT_W'(EXT_W'(cx_ff) - EXT_W'(step_x_ff));
            lower_y_ff    <= OUT_W'(EXT_W'(cy_ff) + EXT_W'(step_y_ff));
            upper_y_ff    <= OUT_W'(EXT_W'(cy_ff) - EXT_W'(step_y_ff));
            out_color_ff  <= color_ff;
            plot_valid_ff <= 1'b1;
            done_ff       <= (step_y_ff == '0);
         end
      end
   end

   assign rsp_right_x     = right_x_ff;
   assign rsp_left_x      = left_x_ff;
   assign rsp_lower_y     = lower_y_ff;
   assign rsp_upper_y     = upper_y_ff;
   assign rsp_point_color = out_color_ff;
   assign rsp_plot_valid  = plot_valid_ff;
   assign rsp_done_res    = done_ff;

   assign status.active     = active_ff;
   assign status.region_two = region_two_ff;
   assign status.r1_cond    = !region_two_ff && (slope_x_ff < slope_y_ff);

   a_step_one_in_region_one : assert property (@(posedge clock) disable iff (reset)
      cmd.dp_op == mer_pkg::DP_STEP_ONE |-> !region_two_ff && (slope_x_ff < slope_y_ff))
      else $error("region one step issued outside region one");

   a_step_two_active : assert property (@(posedge clock) disable iff (reset)
      cmd.dp_op == mer_pkg::DP_STEP_TWO |-> region_two_ff && active_ff)
      else $error("region two step issued while idle or in region one");

   a_point_done_match : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && !cmd.out_blank |=> plot_valid_ff && (done_ff == (step_y_ff == '0)))
      else $error("done flag does not match the y offset of the point");

endmodule

// ===== hw/rtl/mer_ctrl.sv =====
// controller of the ellipse rasterizer: sequencing of start, step and region switch
module mer_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mer_pkg::status_type  status,
   output mer_pkg::cmd_type     cmd
);

   mer_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_fire;
   logic               slot_free;

   assign req_ready = (state_ff == mer_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mer_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_command == mer_pkg::CMD_START) begin
                  state_in = mer_pkg::ST_INIT_RX;
               end else if (!status.active) begin
                  state_in = mer_pkg::ST_EMIT_BLANK;
               end else if (!status.region_two && !status.r1_cond) begin
                  state_in = mer_pkg::ST_SW_U;
               end else begin
                  state_in = mer_pkg::ST_STEP;
               end
            end
         end
         mer_pkg::ST_INIT_RX:    state_in = mer_pkg::ST_INIT_RY;
         mer_pkg::ST_INIT_RY:    state_in = mer_pkg::ST_INIT_PROD;
         mer_pkg::ST_INIT_PROD:  state_in = mer_pkg::ST_INIT_SLOPE;
         mer_pkg::ST_INIT_SLOPE: state_in = mer_pkg::ST_EMIT_PT;
         mer_pkg::ST_SW_U:       state_in = mer_pkg::ST_SW_USQ;
         mer_pkg::ST_SW_USQ:     state_in = mer_pkg::ST_SW_V;
         mer_pkg::ST_SW_V:       state_in = mer_pkg::ST_SW_VSQ;
         mer_pkg::ST_SW_VSQ:     state_in = mer_pkg::ST_SW_W;
         mer_pkg::ST_SW_W:       state_in = mer_pkg::ST_SW_WSQ;
         mer_pkg::ST_SW_WSQ:     state_in = mer_pkg::ST_SW_DONE;
         mer_pkg::ST_SW_DONE:    state_in = mer_pkg::ST_STEP;
         mer_pkg::ST_STEP:       state_in = mer_pkg::ST_DELTA;
         mer_pkg::ST_DELTA:      state_in = mer_pkg::ST_DECIDE;
         mer_pkg::ST_DECIDE:     state_in = mer_pkg::ST_EMIT_PT;
         mer_pkg::ST_EMIT_PT,
         mer_pkg::ST_EMIT_BLANK: begin
            if (slot_free) begin
               state_in = mer_pkg::ST_IDLE;
            end
         end
         default: state_in = mer_pkg::ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.dp_op     = mer_pkg::DP_NOP;
      cmd.mul_sel   = mer_pkg::MUL_IDLE;
      cmd.out_load  = 1'b0;
      cmd.out_blank = 1'b0;
      case (state_ff)
         mer_pkg::ST_IDLE: begin
            if (req_fire && req_command == mer_pkg::CMD_START) begin
               cmd.dp_op = mer_pkg::DP_LOAD;
            end
         end
         mer_pkg::ST_INIT_RX: cmd.mul_sel = mer_pkg::MUL_RX_RX;
         mer_pkg::ST_INIT_RY: begin
            cmd.dp_op   = mer_pkg::DP_INIT_RX2;
            cmd.mul_sel = mer_pkg::MUL_RY_RY;
         end
         mer_pkg::ST_INIT_PROD: begin
            cmd.dp_op   = mer_pkg::DP_INIT_RY2;
            cmd.mul_sel = mer_pkg::MUL_RX2_RY;
         end
         mer_pkg::ST_INIT_SLOPE: cmd.dp_op = mer_pkg::DP_INIT_SLOPE;
         mer_pkg::ST_SW_U:       cmd.mul_sel = mer_pkg::MUL_RY_TX;
         mer_pkg::ST_SW_USQ:     cmd.mul_sel = mer_pkg::MUL_PROD_SQ;
         mer_pkg::ST_SW_V: begin
            cmd.dp_op   = mer_pkg::DP_SW_SET;
            cmd.mul_sel = mer_pkg::MUL_RX_TY;
         end
         mer_pkg::ST_SW_VSQ:     cmd.mul_sel = mer_pkg::MUL_PROD_SQ;
         mer_pkg::ST_SW_W: begin
            cmd.dp_op   = mer_pkg::DP_SW_ADD;
            cmd.mul_sel = mer_pkg::MUL_RX_RY;
         end
         mer_pkg::ST_SW_WSQ:     cmd.mul_sel = mer_pkg::MUL_PROD_SQ;
         mer_pkg::ST_SW_DONE:    cmd.dp_op = mer_pkg::DP_SW_SUB;
         mer_pkg::ST_STEP: begin
            cmd.dp_op = status.r1_cond ? mer_pkg::DP_STEP_ONE : mer_pkg::DP_STEP_TWO;
         end
         mer_pkg::ST_DELTA:      cmd.dp_op = mer_pkg::DP_DELTA;
         mer_pkg::ST_DECIDE:     cmd.dp_op = mer_pkg::DP_DEC_UPD;
         mer_pkg::ST_EMIT_PT: begin
            cmd.out_load = slot_free;
         end
         mer_pkg::ST_EMIT_BLANK: begin
            cmd.out_load  = slot_free;
            cmd.out_blank = 1'b1;
         end
         default: cmd.dp_op = mer_pkg::DP_NOP;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mer_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while an untaken response is held");

   a_idle_advance_blank : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_command == mer_pkg::CMD_ADVANCE && !status.active
      |=> state_ff == mer_pkg::ST_EMIT_BLANK)
      else $error("advance while idle did not lead to a blank response");

   a_start_sequence : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_command == mer_pkg::CMD_START |=> state_ff == mer_pkg::ST_INIT_RX
      ##4 state_ff == mer_pkg::ST_EMIT_PT)
      else $error("start did not run the setup sequence");

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer_unit.sv =====
// top level of the midpoint ellipse rasterizer
//
//  channel   modport            handshake      payload
//  req_chan  mer_req_if.sink    valid/ready    command, center_x/y, radius_x/y, pen_color
//  rsp_chan  mer_rsp_if.source  valid/ready    right_x, left_x, lower_y, upper_y,
//                                              point_color, plot_valid, done_res
//
//  the response register is loaded after init rx, ry, prod and slope for a start, after
//  step, delta and decide for an advance, with sw u to sw done ahead on the one advance
//  that moves from region one to region two, and in emit blank for an advance while idle;
//  req ready returns the cycle after the load; the single shared multiplier and the split
//  decision update set the states; the response sits in a register, so a new request is
//  taken while it waits; an untaken response holds the next load back until rsp ready
//  synchronous active-high reset leaves the unit idle: an advance then answers blank
module midpoint_ellipse_rasterizer_unit #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input logic       clock,
   input logic       reset,
   mer_req_if.sink   req_chan,
   mer_rsp_if.source rsp_chan
);

   // command and status bundles between controller and datapath
   mer_pkg::cmd_type    cmd;
   mer_pkg::status_type status;

   // controller: handshakes, state sequence, response valid
   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath: radii squares, slope terms, scaled decision and the result register
   mer_dp #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_center_x    (req_chan.center_x),
      .req_center_y    (req_chan.center_y),
      .req_radius_x    (req_chan.radius_x),
      .req_radius_y    (req_chan.radius_y),
      .req_pen_color   (req_chan.pen_color),
      .rsp_right_x     (rsp_chan.right_x),
      .rsp_left_x      (rsp_chan.left_x),
      .rsp_lower_y     (rsp_chan.lower_y),
      .rsp_upper_y     (rsp_chan.upper_y),
      .rsp_point_color (rsp_chan.point_color),
      .rsp_plot_valid  (rsp_chan.plot_valid),
      .rsp_done_res    (rsp_chan.done_res)
   );

endmodule
